// ===== sv/sadc_pkg.sv =====
package sadc_pkg;

	// Fixed field widths
	localparam int SUM_W   = 32;
	localparam int AVG_W   = 24;
	localparam int CNT_W   = 8;
	localparam int GAIN_W  = 2;
	localparam int HALF_W  = 8;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 3;

	// Parameter defaults
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int TICK_BITS_DEF   = 8;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_GAIN_PULSES   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_AVERAGE_COUNT = 3'd1;
	localparam logic [CIDX_W-1:0] REG_ZERO_OFFSET   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_HALF_PERIOD   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_POWER_DOWN    = 3'd4;

	// Saturation limits of the net value
	localparam logic [SUM_W-1:0] NET_MAX = 32'h7FFF_FFFF;
	localparam logic [SUM_W-1:0] NET_MIN = 32'h8000_0000;

	// Serial link sequencer status for one tick
	typedef struct packed {
		logic                    clock_level;
		logic                    busy;
		logic                    meas_start;
		logic                    conv_done;
		logic signed [SUM_W-1:0] sample;
	} link_stat_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== sv/sadc_in_if.sv =====
interface sadc_in_if;
	logic valid;
	logic ready;
	logic data_level;
	logic start_request;

	modport source (output valid, output data_level, output start_request, input ready);
	modport sink (input valid, input data_level, input start_request, output ready);
endinterface

// ===== sv/sadc_out_if.sv =====
interface sadc_out_if;
	logic               valid;
	logic               ready;
	logic               clock_level;
	logic               busy_res;
	logic               result_valid;
	logic signed [23:0] average_value;
	logic signed [31:0] net_value;

	modport source (output valid, output clock_level, output busy_res, output result_valid,
		output average_value, output net_value, input ready);
	modport sink (input valid, input clock_level, input busy_res, input result_valid,
		input average_value, input net_value, output ready);
endinterface

// ===== sv/sadc_link.sv =====
// Serial link sequencer: wait for ready, clock the sample in, send gain pulses.
module sadc_link import sadc_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int TICK_COUNT_BITS = TICK_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              data_level,
	input  logic              start_request,
	input  logic [GAIN_W-1:0] gain_pulses,
	input  logic [HALF_W-1:0] half_period_ticks,
	input  logic              power_down,
	input  logic              last_conv,
	output link_stat_t        stat
);

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_WAIT     = 3'd1;
	localparam logic [2:0] PH_SHIFT_HI = 3'd2;
	localparam logic [2:0] PH_SHIFT_LO = 3'd3;
	localparam logic [2:0] PH_PULSE_HI = 3'd4;
	localparam logic [2:0] PH_PULSE_LO = 3'd5;

	localparam int CmpW = (TICK_COUNT_BITS > HALF_W ? TICK_COUNT_BITS : HALF_W) + 1;
	localparam logic [CmpW-1:0] TickLimit = CmpW'(1) << TICK_COUNT_BITS;

	logic [2:0]                 phase_q, phase_d, ph;
	logic [4:0]                 bit_idx_q, bit_idx_d, bi_inc;
	logic [TICK_COUNT_BITS-1:0] htc_q, htc_d;
	logic [SAMPLE_BITS-1:0]     shift_q, shift_d;
	logic [GAIN_W-1:0]          pulse_q, pulse_d, pc_inc, np;
	logic [CmpW-1:0]            tgt, cnt_inc;
	logic                       hp_end;

	// Half period counter compare
	always_comb begin
		tgt = CmpW'(half_period_ticks);
		if (tgt == '0) begin
			tgt = CmpW'(1);
		end
		if (tgt > TickLimit) begin
			tgt = TickLimit;
		end
		cnt_inc = CmpW'(htc_q) + CmpW'(1);
		hp_end  = (cnt_inc >= tgt);
	end

	assign bi_inc = bit_idx_q + 5'd1;
	assign pc_inc = pulse_q + 2'd1;
	assign np     = (gain_pulses == '0) ? GAIN_W'(1) : gain_pulses;
	assign ph     = (phase_q > PH_PULSE_LO) ? PH_IDLE : phase_q;

	// Next state for one tick
	always_comb begin
		phase_d   = ph;
		bit_idx_d = bit_idx_q;
		htc_d     = htc_q;
		shift_d   = shift_q;
		pulse_d   = pulse_q;
		stat.clock_level = 1'b0;
		stat.busy        = (ph != PH_IDLE);
		stat.meas_start  = 1'b0;
		stat.conv_done   = 1'b0;
		stat.sample      = SUM_W'(signed'(shift_q));
		if (power_down) begin
			stat.clock_level = 1'b1;
			phase_d = PH_IDLE;
			htc_d   = '0;
		end else begin
			case (ph)
				PH_IDLE: begin
					if (start_request) begin
						phase_d = PH_WAIT;
						stat.meas_start = 1'b1;
					end
				end
				PH_WAIT: begin
					if (!data_level) begin
						phase_d   = PH_SHIFT_HI;
						bit_idx_d = '0;
						htc_d     = '0;
						shift_d   = '0;
					end
				end
				PH_SHIFT_HI: begin
					stat.clock_level = 1'b1;
					htc_d = hp_end ? '0 : htc_q + 1'b1;
					if (hp_end) begin
						shift_d = {shift_q[SAMPLE_BITS-2:0], data_level};
						phase_d = PH_SHIFT_LO;
					end
				end
				PH_SHIFT_LO: begin
					htc_d = hp_end ? '0 : htc_q + 1'b1;
					if (hp_end) begin
						bit_idx_d = bi_inc;
						if (bi_inc >= 5'(SAMPLE_BITS)) begin
							phase_d = PH_PULSE_HI;
							pulse_d = '0;
						end else begin
							phase_d = PH_SHIFT_HI;
						end
					end
				end
				PH_PULSE_HI: begin
					stat.clock_level = 1'b1;
					htc_d = hp_end ? '0 : htc_q + 1'b1;
					if (hp_end) begin
						phase_d = PH_PULSE_LO;
					end
				end
				PH_PULSE_LO: begin
					htc_d = hp_end ? '0 : htc_q + 1'b1;
					if (hp_end) begin
						pulse_d = pc_inc;
						if (pc_inc < np) begin
							phase_d = PH_PULSE_HI;
						end else begin
							stat.conv_done = 1'b1;
							phase_d = last_conv ? PH_IDLE : PH_WAIT;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_idx_q <= '0;
			htc_q     <= '0;
			shift_q   <= '0;
			pulse_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			bit_idx_q <= bit_idx_d;
			htc_q     <= htc_d;
			shift_q   <= shift_d;
			pulse_q   <= pulse_d;
		end
	end

endmodule

// ===== sv/sadc_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero.
module sadc_div import sadc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output div_stat_t               stat,
	output logic signed [SUM_W-1:0] quotient
);

	localparam int IterW = $clog2(SUM_W);

	logic             act_q, fix_q, done_q;
	logic [IterW-1:0] cnt_q;
	logic [CNT_W-1:0] rem_q, dvs_q;
	logic [SUM_W-1:0] quo_q;
	logic             neg_q;
	logic [CNT_W:0]   trial, diff;
	logic             ge;

	// Restoring step
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= !start && act_q && (cnt_q == '1);
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (act_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end else if (fix_q) begin
			quo_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	assign stat.busy = act_q | fix_q | done_q;
	assign stat.done = done_q;
	assign quotient  = signed'(quo_q);

endmodule

// ===== sv/serial_adc_read_average.sv =====
// Timing: a tick that does not end a measurement gives its word in the cycle after acceptance.
// The tick that ends a measurement gives its word once the 32-step serial divider has run
// (pend_q, the divider steps, its sign fix and done stage, the output register); no tick is accepted meanwhile.
// Throughput: one tick per cycle otherwise, while the output is not held back; one word out per tick.
// Reset: registers go to gain 1, count 1, offset 0, half period 1, powered up; sequencer
// idle, held average and net value zero. No clearing pass.
module serial_adc_read_average import sadc_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int TICK_COUNT_BITS = TICK_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	sadc_in_if.sink           in_ch,
	sadc_out_if.source        out_ch,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic [GAIN_W-1:0] gain_q;
	logic [CNT_W-1:0]  avg_cnt_q;
	logic [SUM_W-1:0]  offset_q;
	logic [HALF_W-1:0] half_q;
	logic              pd_q;

	logic [CNT_W-1:0]  rc_q, rc_inc, n_eff;
	logic [SUM_W-1:0]  sum_q;
	logic              pend_q;
	logic              last_conv, in_acc, final_tick;
	logic              out_valid_q, out_clk_q, out_busy_q, out_rv_q;
	logic [AVG_W-1:0]  last_avg_q;
	logic [SUM_W-1:0]  last_net_q;

	link_stat_t              lstat;
	div_stat_t               dstat;
	logic signed [SUM_W-1:0] quotient;
	logic signed [SUM_W:0]   net_wide;
	logic [SUM_W-1:0]        net_sat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_W'(1);
			avg_cnt_q <= CNT_W'(1);
			offset_q  <= '0;
			half_q    <= HALF_W'(1);
			pd_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GAIN_PULSES:   gain_q    <= cfg_data[GAIN_W-1:0];
				REG_AVERAGE_COUNT: avg_cnt_q <= cfg_data[CNT_W-1:0];
				REG_ZERO_OFFSET:   offset_q  <= cfg_data[SUM_W-1:0];
				REG_HALF_PERIOD:   half_q    <= cfg_data[HALF_W-1:0];
				REG_POWER_DOWN:    pd_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Handshake: stall while a measurement is pending or being divided, or while the output word is held
	assign in_ch.ready = !pend_q && !dstat.busy && (!out_valid_q || out_ch.ready);
	assign in_acc      = in_ch.valid && in_ch.ready;

	assign n_eff     = (avg_cnt_q == '0) ? CNT_W'(1) : avg_cnt_q;
	assign rc_inc    = rc_q + 1'b1;
	assign last_conv = (rc_inc >= n_eff);

	sadc_link #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.TICK_COUNT_BITS (TICK_COUNT_BITS)
	) u_link (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (in_acc),
		.data_level        (in_ch.data_level),
		.start_request     (in_ch.start_request),
		.gain_pulses       (gain_q),
		.half_period_ticks (half_q),
		.power_down        (pd_q),
		.last_conv         (last_conv),
		.stat              (lstat)
	);

	assign final_tick = lstat.conv_done && last_conv;

	// Accumulator and conversion count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q   <= '0;
			sum_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= in_acc && final_tick;
			if (in_acc) begin
				if (lstat.meas_start) begin
					rc_q  <= '0;
					sum_q <= '0;
				end else if (lstat.conv_done) begin
					rc_q  <= rc_inc;
					sum_q <= sum_q + lstat.sample;
				end
			end
		end
	end

	sadc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pend_q),
		.dividend (signed'(sum_q)),
		.divisor  (n_eff),
		.stat     (dstat),
		.quotient (quotient)
	);

	// Net value with saturation
	always_comb begin
		net_wide = {quotient[SUM_W-1], quotient} - {offset_q[SUM_W-1], offset_q};
		if (net_wide[SUM_W] != net_wide[SUM_W-1]) begin
			net_sat = net_wide[SUM_W] ? NET_MIN : NET_MAX;
		end else begin
			net_sat = net_wide[SUM_W-1:0];
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_clk_q   <= 1'b0;
			out_busy_q  <= 1'b0;
			out_rv_q    <= 1'b0;
			last_avg_q  <= '0;
			last_net_q  <= '0;
		end else begin
			if (dstat.done) begin
				out_valid_q <= 1'b1;
				out_clk_q   <= 1'b0;
				out_busy_q  <= 1'b1;
				out_rv_q    <= 1'b1;
				last_avg_q  <= quotient[AVG_W-1:0];
				last_net_q  <= net_sat;
			end else if (in_acc && !final_tick) begin
				out_valid_q <= 1'b1;
				out_clk_q   <= lstat.clock_level;
				out_busy_q  <= lstat.busy;
				out_rv_q    <= 1'b0;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.clock_level   = out_clk_q;
	assign out_ch.busy_res      = out_busy_q;
	assign out_ch.result_valid  = out_rv_q;
	assign out_ch.average_value = signed'(last_avg_q);
	assign out_ch.net_value     = signed'(last_net_q);

	// A finished measurement word is always a busy, clock-low word
	a_result_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_rv_q |-> out_busy_q && !out_clk_q)
		else $error("result word with wrong clock or busy level");

	// No tick is taken while the divider owns the result
	a_no_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy || pend_q |-> !in_ch.ready)
		else $error("tick accepted during division");

	// A pending measurement starts the divider on the next cycle
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> dstat.busy)
		else $error("divider not started");

	// Power down drives the serial clock high
	a_pd_clock: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pd_q |=> out_valid_q && out_clk_q && !out_rv_q)
		else $error("clock not held high in power down");

endmodule
